@@ rtl/core/gsed_pkg.sv @@
// Package with the shared types and constants of the graph line decoder.
package gsed_pkg;

    // Largest vertex count the decoder accepts; the count and index widths are sized for it.
    localparam int MAX_VERTICES = 128;

    localparam logic [7:0] CHAR_SPARSE  = 8'h3A;
    localparam logic [7:0] CHAR_DIGRAPH = 8'h26;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] ASCII_BIAS   = 8'd63;
    localparam logic [7:0] ASCII_TOP    = 8'd126;

    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SIZE     = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL  = 3'd2;
    localparam logic [2:0] ERR_TRUNC    = 3'd3;
    localparam logic [2:0] ERR_OVERLONG = 3'd4;

    // Byte class handed from the front part to the back part.
    typedef enum logic [1:0] {
        CLS_DATA  = 2'd0,
        CLS_TERM  = 2'd1,
        CLS_ILLEG = 2'd2
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [7:0] char_val;
        logic [5:0] data;
        logic       line_end;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] vertex_total;
        logic [6:0] edge_from;
        logic [6:0] edge_to;
        logic [2:0] error_code;
        logic       last_of_run;
    } t_res;

endpackage

@@ rtl/core/gsed_front.sv @@
// Front part: accepts bytes, classifies them and queues them for the back part.
module gsed_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_char_in,
    input  logic          i_line_end,
    output logic          o_full,
    output gsed_pkg::t_req o_req,
    output logic          o_req_valid,
    input  logic          i_req_take
);
    import gsed_pkg::*;

    localparam int DEPTH = 4;

    t_req       r_mem [DEPTH];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count;
    t_req       w_req;
    logic       w_wr, w_rd;

    always_comb begin
        w_req.char_val = i_char_in;
        w_req.line_end = i_line_end;
        w_req.data     = 6'(i_char_in - ASCII_BIAS);
        if (i_char_in == CHAR_NL || i_char_in == CHAR_NUL) begin
            w_req.cls = CLS_TERM;
        end else if (i_char_in < ASCII_BIAS || i_char_in > ASCII_TOP) begin
            w_req.cls = CLS_ILLEG;
        end else begin
            w_req.cls = CLS_DATA;
        end
    end

    assign o_full      = (r_count == 3'(DEPTH));
    assign o_req_valid = (r_count != 3'd0);
    assign o_req       = r_mem[r_rptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) r_wptr <= r_wptr + 2'd1;
            if (w_rd) r_rptr <= r_rptr + 2'd1;
            r_count <= r_count + {2'b0, w_wr} - {2'b0, w_rd};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH)) else $error("request queue overflow");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_rd |=> o_full) else $error("full dropped without a take");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && !w_rd |=> r_count == $past(r_count) + 3'd1)
        else $error("queue count did not advance");
`endif
endmodule

@@ rtl/core/gsed_back.sv @@
// Back part: runs the line parser, one bit per cycle while the result queue has two free entries.
module gsed_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gsed_pkg::t_req i_req,
    input  logic           i_req_valid,
    output logic           o_req_take,
    output gsed_pkg::t_res o_res,
    output logic           o_res_valid,
    input  logic           i_res_take
);
    import gsed_pkg::*;

    localparam int QD = 4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BITS = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_ERR  = 4'b1000
    } t_state;

    // Parser state per line.
    logic [1:0]  r_fmt;
    logic [2:0]  r_phase;
    logic [35:0] r_acc;
    logic [2:0]  r_hleft;
    logic [7:0]  r_n;
    logic [6:0]  r_row;
    logic [7:0]  r_col;
    logic [7:0]  r_sv;
    logic [6:0]  r_sx;
    logic [2:0]  r_need;
    logic [2:0]  r_iw;
    logic        r_inrec;

    t_state      r_st;
    logic [5:0]  r_d;
    logic [2:0]  r_k;
    logic        r_le;
    logic [2:0]  r_errc;

    // Result queue.
    t_res        r_q [QD];
    logic [1:0]  r_qw, r_qr;
    logic [2:0]  r_qc;
    logic        w_qfull;
    logic        w_room2;

    logic        w_emit;
    t_res        w_res;

    logic [1:0]  n_fmt;
    logic [2:0]  n_phase;
    logic [35:0] n_acc;
    logic [2:0]  n_hleft;
    logic [7:0]  n_n;
    logic [6:0]  n_row;
    logic [7:0]  n_col;
    logic [7:0]  n_sv;
    logic [6:0]  n_sx;
    logic [2:0]  n_need;
    logic [2:0]  n_iw;
    logic        n_inrec;
    t_state      n_st;
    logic [5:0]  n_d;
    logic [2:0]  n_k;
    logic        n_le;
    logic [2:0]  n_errc;
    logic        w_take;

    // Edge results of a body byte are held back one slot so the final one can be flagged.
    t_res        r_hold;
    logic        r_hold_v;
    t_res        n_hold;
    logic        n_hold_v;
    logic        w_wr0, w_wr1;
    t_res        w_wr0_res, w_wr1_res;

    assign w_qfull     = (r_qc == 3'(QD));
    assign w_room2     = (r_qc <= 3'(QD - 2));
    assign o_res_valid = (r_qc != 3'd0);
    assign o_res       = r_q[r_qr];
    assign o_req_take  = w_take;

    // Width of n-1 in bits.
    function automatic logic [2:0] f_iw(input logic [7:0] n);
        logic [7:0] t;
        logic [2:0] w;
        t = (n != 8'd0) ? n - 8'd1 : 8'd0;
        w = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (t[i]) w = 3'(i + 1);
        end
        return w;
    endfunction

    always_comb begin
        logic [35:0] sz;
        logic        szd;
        logic        bit_v;
        logic [6:0]  j;
        logic        more;

        n_fmt = r_fmt; n_phase = r_phase; n_acc = r_acc; n_hleft = r_hleft;
        n_n = r_n; n_row = r_row; n_col = r_col; n_sv = r_sv; n_sx = r_sx;
        n_need = r_need; n_iw = r_iw; n_inrec = r_inrec;
        n_st = r_st; n_d = r_d; n_k = r_k; n_le = r_le; n_errc = r_errc;
        w_take = 1'b0;
        w_emit = 1'b0;
        w_res  = '0;
        sz = '0; szd = 1'b0; bit_v = 1'b0; j = '0; more = 1'b0;

        case (r_st)
            ST_IDLE: begin
                if (i_req_valid && !w_qfull) begin
                    w_take    = 1'b1;
                    n_le      = i_req.line_end;
                    if (i_req.cls == CLS_TERM) begin
                        n_st = ST_FIN;
                    end else if (r_phase == 3'd6) begin
                        n_st = i_req.line_end ? ST_FIN : ST_IDLE;
                    end else if (r_phase == 3'd0 && i_req.char_val == CHAR_SPARSE) begin
                        n_fmt = 2'd3; n_phase = 3'd1;
                        n_st = i_req.line_end ? ST_FIN : ST_IDLE;
                    end else if (r_phase == 3'd0 && i_req.char_val == CHAR_DIGRAPH) begin
                        n_fmt = 2'd2; n_phase = 3'd1;
                        n_st = i_req.line_end ? ST_FIN : ST_IDLE;
                    end else begin
                        if (r_phase == 3'd0) begin
                            n_fmt = 2'd1; n_phase = 3'd1;
                        end
                        n_st = i_req.line_end ? ST_FIN : ST_IDLE;
                        if (i_req.cls == CLS_ILLEG) begin
                            n_errc = ERR_ILLEGAL; n_st = ST_ERR;
                        end else begin
                            case (n_phase)
                                3'd1: begin
                                    if (i_req.data != 6'd63) begin
                                        sz = 36'(i_req.data); szd = 1'b1;
                                    end else begin
                                        n_phase = 3'd2;
                                    end
                                end
                                3'd2: begin
                                    if (i_req.data != 6'd63) begin
                                        n_acc = 36'(i_req.data); n_hleft = 3'd2;
                                    end else begin
                                        n_acc = '0; n_hleft = 3'd6;
                                    end
                                    n_phase = 3'd3;
                                end
                                3'd3: begin
                                    n_acc   = {r_acc[29:0], i_req.data};
                                    n_hleft = r_hleft - 3'd1;
                                    if (n_hleft == 3'd0) begin
                                        sz = n_acc; szd = 1'b1;
                                    end
                                end
                                3'd4: begin
                                    n_d = i_req.data; n_k = 3'd0; n_st = ST_BITS;
                                end
                                default: begin
                                    n_errc = ERR_OVERLONG; n_st = ST_ERR;
                                end
                            endcase
                            if (szd) begin
                                n_acc = sz;
                                if (sz > 36'(MAX_VERTICES)) begin
                                    n_errc = ERR_SIZE; n_st = ST_ERR;
                                end else begin
                                    n_n = sz[7:0];
                                    w_emit = 1'b1;
                                    w_res.kind = KIND_COUNT;
                                    w_res.vertex_total = n_n;
                                    w_res.last_of_run = !i_req.line_end;
                                    n_phase = 3'd4; n_row = '0;
                                    if (n_fmt == 2'd1) begin
                                        n_col = 8'd1;
                                        if (n_n < 8'd2) n_phase = 3'd5;
                                    end else if (n_fmt == 2'd2) begin
                                        n_col = 8'd0;
                                        if (n_n == 8'd0) n_phase = 3'd5;
                                    end else begin
                                        n_iw = f_iw(n_n); n_sv = '0; n_inrec = 1'b0;
                                        n_sx = '0; n_need = '0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ST_ERR: begin
                if (!w_qfull) begin
                    // Nothing follows an error on its line, so it always closes the byte.
                    w_emit = 1'b1;
                    w_res.kind = KIND_ERROR; w_res.error_code = r_errc;
                    w_res.last_of_run = 1'b1;
                    n_phase = 3'd6;
                    n_st = r_le ? ST_FIN : ST_IDLE;
                end
            end
            ST_BITS: begin
                if (w_room2) begin
                    bit_v = r_d[3'd5 - r_k];
                    more  = (r_k != 3'd5);
                    if (r_fmt == 2'd3) begin
                        if (!r_inrec) begin
                            if (bit_v && r_sv < r_n) n_sv = r_sv + 8'd1;
                            n_inrec = 1'b1; n_sx = '0; n_need = r_iw;
                            j = '0;
                        end else begin
                            n_sx = {r_sx[5:0], bit_v}; n_need = r_need - 3'd1;
                            j = n_sx;
                        end
                        if (n_need == 3'd0) begin
                            n_inrec = 1'b0;
                            if ({1'b0, j} > n_sv) begin
                                n_sv = {1'b0, j};
                            end else if (n_sv < r_n) begin
                                w_emit = 1'b1;
                                w_res.kind = KIND_EDGE;
                                w_res.edge_from = j; w_res.edge_to = n_sv[6:0];
                            end
                        end
                    end else if (r_phase == 3'd4) begin
                        if (bit_v) begin
                            w_emit = 1'b1;
                            w_res.kind = KIND_EDGE;
                            w_res.edge_from = r_row; w_res.edge_to = r_col[6:0];
                        end
                        if (r_fmt == 2'd1) begin
                            n_row = r_row + 7'd1;
                            if ({1'b0, n_row} >= r_col) begin
                                n_row = '0; n_col = r_col + 8'd1;
                                if (n_col >= r_n) n_phase = 3'd5;
                            end
                        end else begin
                            n_col = r_col + 8'd1;
                            if (n_col >= r_n) begin
                                n_col = '0; n_row = r_row + 7'd1;
                                // The row can reach 128, which needs the eighth bit.
                                if ({1'b0, r_row} + 8'd1 >= r_n) n_phase = 3'd5;
                            end
                        end
                    end
                    // The flag of the final edge of the byte is set in the queue write logic below.
                    w_res.last_of_run = 1'b0;
                    n_k = r_k + 3'd1;
                    if (!more) begin
                        n_st = r_le ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (w_room2) begin
                    if (r_phase == 3'd6) begin
                        w_emit = 1'b0;
                    end else if ((r_phase == 3'd4 && r_fmt == 2'd3) || r_phase == 3'd5) begin
                        w_emit = 1'b1; w_res.kind = KIND_DONE;
                    end else begin
                        w_emit = 1'b1; w_res.kind = KIND_ERROR;
                        w_res.error_code = ERR_TRUNC;
                    end
                    w_res.last_of_run = 1'b1;
                    n_fmt = '0; n_phase = '0; n_acc = '0; n_hleft = '0; n_n = '0;
                    n_row = '0; n_col = '0; n_sv = '0; n_sx = '0; n_need = '0;
                    n_iw = '0; n_inrec = 1'b0;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Queue writes: up to two a cycle, the held edge first and then the new result.
    always_comb begin
        w_wr0 = 1'b0;
        w_wr1 = 1'b0;
        w_wr0_res = w_res;
        w_wr1_res = w_res;
        n_hold = r_hold;
        n_hold_v = r_hold_v;
        case (r_st)
            ST_BITS: begin
                if (w_room2) begin
                    if (w_emit) begin
                        if (r_hold_v) begin
                            w_wr0 = 1'b1; w_wr0_res = r_hold;
                        end
                        if (r_k == 3'd5 && !r_le) begin
                            // Final bit without a line end: the new edge closes the byte.
                            if (r_hold_v) begin
                                w_wr1 = 1'b1; w_wr1_res.last_of_run = 1'b1;
                            end else begin
                                w_wr0 = 1'b1; w_wr0_res.last_of_run = 1'b1;
                            end
                            n_hold_v = 1'b0;
                        end else begin
                            n_hold = w_res; n_hold_v = 1'b1;
                        end
                    end else if (r_k == 3'd5 && !r_le && r_hold_v) begin
                        w_wr0 = 1'b1; w_wr0_res = r_hold; w_wr0_res.last_of_run = 1'b1;
                        n_hold_v = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                if (w_room2) begin
                    if (r_hold_v) begin
                        w_wr0 = 1'b1; w_wr0_res = r_hold; w_wr0_res.last_of_run = !w_emit;
                        w_wr1 = w_emit;
                        n_hold_v = 1'b0;
                    end else begin
                        w_wr0 = w_emit;
                    end
                end
            end
            default: w_wr0 = w_emit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr0) r_q[r_qw] <= w_wr0_res;
        if (w_wr1) r_q[r_qw + 2'd1] <= w_wr1_res;
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_fmt <= '0; r_phase <= '0; r_acc <= '0; r_hleft <= '0;
            r_n <= '0; r_row <= '0; r_col <= '0; r_sv <= '0; r_sx <= '0;
            r_need <= '0; r_iw <= '0; r_inrec <= 1'b0; r_d <= '0; r_k <= '0;
            r_le <= 1'b0; r_errc <= '0;
            r_hold_v <= 1'b0;
            r_qw <= '0; r_qr <= '0; r_qc <= '0;
        end else begin
            r_st <= n_st; r_fmt <= n_fmt; r_phase <= n_phase; r_acc <= n_acc;
            r_hleft <= n_hleft; r_n <= n_n; r_row <= n_row; r_col <= n_col;
            r_sv <= n_sv; r_sx <= n_sx; r_need <= n_need; r_iw <= n_iw;
            r_inrec <= n_inrec; r_d <= n_d; r_k <= n_k; r_le <= n_le;
            r_errc <= n_errc;
            r_hold_v <= n_hold_v;
            r_qw <= r_qw + {1'b0, w_wr0} + {1'b0, w_wr1};
            if (i_res_take && o_res_valid) r_qr <= r_qr + 2'd1;
            r_qc <= r_qc + {2'b0, w_wr0} + {2'b0, w_wr1}
                    - {2'b0, i_res_take && o_res_valid};
        end
    end

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qc <= 3'(QD)) else $error("result queue overflow");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("parser state lost its one-hot code");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_st == ST_IDLE) else $error("request taken while busy");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_FIN && w_room2 |=> r_phase == 3'd0)
        else $error("line finish left parser state");
`endif
endmodule

@@ rtl/core/graph6_sparse6_edge_decoder_unit.sv @@
// Top level of the graph6, digraph6 and sparse6 line decoder.
//
//  channel   direction  handshake         payload
//  request   in         push / full        i_char_in, i_line_end
//  result    out        empty / pop        o_kind .. o_last_of_run
//
// A header byte is handled as the parser takes it; a body byte is taken and then
// walked one bit at a time, six bits; an error or a line finish adds a further state.
// The body bit walk sets the rate. The bit walk and the line finish wait while
// the result queue has fewer than two free entries.
// Reset is synchronous and active low; it clears both queues and the parser.
// A four entry request queue lets the input run ahead while results stall,
// and a four entry result queue lets results drain while the parser works.
module graph6_sparse6_edge_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_vertex_total,
    output logic [6:0] o_edge_from,
    output logic [6:0] o_edge_to,
    output logic [2:0] o_error_code,
    output logic       o_last_of_run
);
    import gsed_pkg::*;

    t_req w_req;
    logic w_req_valid, w_req_take, w_res_valid;
    t_res w_res;

    gsed_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_char_in, .i_line_end,
        .o_full(full), .o_req(w_req), .o_req_valid(w_req_valid),
        .i_req_take(w_req_take)
    );

    gsed_back u_back (
        .i_clk, .i_rst_n, .i_req(w_req), .i_req_valid(w_req_valid),
        .o_req_take(w_req_take), .o_res(w_res), .o_res_valid(w_res_valid),
        .i_res_take(pop)
    );

    assign empty          = !w_res_valid;
    assign o_kind         = w_res.kind;
    assign o_vertex_total = w_res.vertex_total;
    assign o_edge_from    = w_res.edge_from;
    assign o_edge_to      = w_res.edge_to;
    assign o_error_code   = w_res.error_code;
    assign o_last_of_run  = w_res.last_of_run;

`ifndef SYNTHESIS
    a_kind_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_ERROR |-> o_error_code != ERR_NONE)
        else $error("error result without a code");
    a_count_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_COUNT |-> 32'(o_vertex_total) <= MAX_VERTICES)
        else $error("vertex count above limit");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_DONE |-> o_last_of_run)
        else $error("line finish not flagged last");
`endif
endmodule
